/* rtl/core/dns_name_label_encoder_macros.svh */
// assertion macros for the dns name label encoder checker
// no dependencies; included by files that carry concurrent assertions
`ifndef DNS_NAME_LABEL_ENCODER_MACROS_SVH
`define DNS_NAME_LABEL_ENCODER_MACROS_SVH

// clocked check, disabled while reset is asserted
`define DNSLE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define DNSLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/dnsle_pkg.sv */
// shared types and constants of the dns name label encoder
// no dependencies; used by every module of the block
package dnsle_pkg;

	localparam int MAX_LABEL_DEF = 61;
	localparam int LEN_W = 6;

	localparam logic       FUNC_CHAR    = 1'b0;
	localparam logic       FUNC_END     = 1'b1;
	localparam logic [7:0] DOT_CHAR     = 8'h2E;
	localparam logic [15:0] NO_POINTER  = 16'hFFFF;
	localparam logic [7:0] POINTER_MARK = 8'hC0;

	typedef struct packed {
		logic        func;
		logic [7:0]  ch;
		logic [15:0] pointer_offset;
	} name_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       label_overflow;
	} code_item_t;

	// work queued from front to back
	typedef struct packed {
		logic             has_label;
		logic             is_end;
		logic             bank;
		logic [LEN_W-1:0] count;
		logic             ovf;
		logic [15:0]      offset;
	} cmd_t;

	// label buffer write from the front
	typedef struct packed {
		logic             en;
		logic             bank;
		logic [LEN_W-1:0] idx;
		logic [7:0]       data;
	} lbuf_wr_t;

	// back hands a replayed bank back to the front
	typedef struct packed {
		logic en;
		logic bank;
	} bank_rel_t;

endpackage

/* rtl/core/dnsle_front.sv */
// front part: accepts name items, tracks the open label, issues work
// depends on dnsle_pkg
module dnsle_front #(
	parameter int MAX_LABEL = dnsle_pkg::MAX_LABEL_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   name_valid,
	output logic                   name_stall,
	input  dnsle_pkg::name_item_t  name,
	output logic                   push,
	output dnsle_pkg::cmd_t        push_cmd,
	input  logic                   q_full,
	output dnsle_pkg::lbuf_wr_t    wr,
	input  dnsle_pkg::bank_rel_t   rel
);

	logic [dnsle_pkg::LEN_W-1:0] count_q;
	logic                        ovf_q;
	logic                        wbank_q;
	logic [1:0]                  busy_q;

	logic is_dot;
	logic need_push;
	logic has_label;
	logic accept;
	logic full_label;
	logic [1:0] busy_set;
	logic [1:0] busy_clr;

	assign is_dot     = (name.func == dnsle_pkg::FUNC_CHAR) && (name.ch == dnsle_pkg::DOT_CHAR);
	assign has_label  = (count_q != '0);
	assign need_push  = (name.func == dnsle_pkg::FUNC_END) || (is_dot && has_label);
	assign name_stall = need_push && (q_full || (has_label && busy_q[~wbank_q]));
	assign accept     = name_valid && !name_stall;
	assign full_label = (count_q >= dnsle_pkg::LEN_W'(MAX_LABEL));

	assign push = accept && need_push;

	always_comb begin
		push_cmd.has_label = has_label;
		push_cmd.is_end    = (name.func == dnsle_pkg::FUNC_END);
		push_cmd.bank      = wbank_q;
		push_cmd.count     = count_q;
		push_cmd.ovf       = ovf_q;
		push_cmd.offset    = name.pointer_offset;
	end

	always_comb begin
		wr.en   = accept && (name.func == dnsle_pkg::FUNC_CHAR) && !is_dot && !full_label;
		wr.bank = wbank_q;
		wr.idx  = count_q;
		wr.data = name.ch;
	end

	// bank taken by a pushed label, bank handed back by the back part
	always_comb begin
		busy_set = 2'b00;
		busy_clr = 2'b00;
		if (rel.en) begin
			busy_clr[rel.bank] = 1'b1;
		end
		if (push && has_label) begin
			busy_set[wbank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			wbank_q <= 1'b0;
			busy_q  <= 2'b00;
		end else begin
			busy_q <= (busy_q & ~busy_clr) | busy_set;
			if (accept) begin
				if ((name.func == dnsle_pkg::FUNC_END) || is_dot) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					if (has_label) begin
						wbank_q <= ~wbank_q;
					end
				end else if (!full_label) begin
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/core/dnsle_queue.sv */
// two-entry work queue between front and back
// depends on dnsle_pkg
module dnsle_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dnsle_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output dnsle_pkg::cmd_t head,
	output logic            empty
);

	dnsle_pkg::cmd_t entry_q [2];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      fill_q;

	assign full  = (fill_q == 2'd2);
	assign empty = (fill_q == 2'd0);
	assign head  = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* rtl/core/dnsle_back.sv */
// back part: label buffer memory and the byte sequencer that drives the code channel
// depends on dnsle_pkg
module dnsle_back #(
	parameter int MAX_LABEL = dnsle_pkg::MAX_LABEL_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dnsle_pkg::lbuf_wr_t   wr,
	input  dnsle_pkg::cmd_t       head,
	input  logic                  q_empty,
	output logic                  pop,
	output dnsle_pkg::bank_rel_t  rel,
	output logic                  code_valid,
	input  logic                  code_stall,
	output dnsle_pkg::code_item_t code
);

	localparam int DEPTH = 2 * MAX_LABEL;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_LEN     = 3'd1;
	localparam logic [2:0] ST_DATA    = 3'd2;
	localparam logic [2:0] ST_TERM_HI = 3'd3;
	localparam logic [2:0] ST_TERM_LO = 3'd4;

	logic [7:0] mem [DEPTH];

	logic [2:0]                  state_q;
	dnsle_pkg::cmd_t             cmd_q;
	logic [dnsle_pkg::LEN_W-1:0] idx_q;
	logic [7:0]                  rd_data_q;
	logic                        code_valid_q;
	dnsle_pkg::code_item_t       code_q;

	logic                        adv;
	logic                        last_idx;
	logic [dnsle_pkg::LEN_W-1:0] rd_idx;
	logic [AW-1:0]               rd_addr;
	logic [AW-1:0]               wr_addr;

	assign adv      = !code_valid_q || !code_stall;
	assign last_idx = (idx_q == (cmd_q.count - 1'b1));
	assign pop      = (state_q == ST_IDLE) && !q_empty;

	assign rd_idx  = ((state_q == ST_DATA) && adv && !last_idx) ? idx_q + 1'b1 : idx_q;
	assign rd_addr = AW'(rd_idx) + (cmd_q.bank ? AW'(MAX_LABEL) : '0);
	assign wr_addr = AW'(wr.idx) + (wr.bank ? AW'(MAX_LABEL) : '0);

	assign rel.en   = (state_q == ST_DATA) && adv && last_idx;
	assign rel.bank = cmd_q.bank;

	assign code_valid = code_valid_q;
	assign code       = code_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			code_valid_q <= 1'b0;
			code_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (adv) begin
						code_valid_q <= 1'b0;
					end
					if (!q_empty) begin
						idx_q <= '0;
						if (head.has_label) begin
							state_q <= ST_LEN;
						end else begin
							state_q <= ST_TERM_HI;
						end
					end
				end
				ST_LEN: begin
					if (adv) begin
						code_valid_q        <= 1'b1;
						code_q.out_byte       <= 8'(cmd_q.count);
						code_q.last           <= 1'b0;
						code_q.label_overflow <= cmd_q.ovf;
						state_q               <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (adv) begin
						code_valid_q          <= 1'b1;
						code_q.out_byte       <= rd_data_q;
						code_q.last           <= last_idx && !cmd_q.is_end;
						code_q.label_overflow <= cmd_q.ovf;
						if (last_idx) begin
							state_q <= cmd_q.is_end ? ST_TERM_HI : ST_IDLE;
						end else begin
							idx_q <= rd_idx;
						end
					end
				end
				ST_TERM_HI: begin
					if (adv) begin
						code_valid_q          <= 1'b1;
						code_q.label_overflow <= 1'b0;
						if (cmd_q.offset == dnsle_pkg::NO_POINTER) begin
							code_q.out_byte <= 8'h00;
							code_q.last     <= 1'b1;
							state_q         <= ST_IDLE;
						end else begin
							code_q.out_byte <= dnsle_pkg::POINTER_MARK | cmd_q.offset[15:8];
							code_q.last     <= 1'b0;
							state_q         <= ST_TERM_LO;
						end
					end
				end
				ST_TERM_LO: begin
					if (adv) begin
						code_valid_q          <= 1'b1;
						code_q.out_byte       <= cmd_q.offset[7:0];
						code_q.last           <= 1'b1;
						code_q.label_overflow <= 1'b0;
						state_q               <= ST_IDLE;
					end
				end
				default: begin
					if (adv) begin
						code_valid_q <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/core/dns_name_label_encoder.sv */
// top level of the dns name label encoder: dotted name in, wire-format name bytes out
// depends on dnsle_pkg, dnsle_front, dnsle_queue, dnsle_back
//
//   channel  dir  handshake              payload
//   name     in   name_valid/name_stall  dnsle_pkg::name_item_t (func, ch, pointer_offset)
//   code     out  code_valid/code_stall  dnsle_pkg::code_item_t (out_byte, last, label_overflow)
//
// a plain name character is written straight into the label buffer unless the label is already full
// a label replays through the back sequencer (pop, length byte, then one byte per cycle unless
// code stalls, from the registered memory read port); a terminator is a zero byte or two pointer bytes
// two label banks and a two-entry queue let the front fill one label while the back replays
// the previous one; a flush stalls only while both banks or both queue entries are in use
// arst_n clears the sequencer, the queue and the label counters; buffer contents are not reset
// a stall on code holds the output register and freezes the sequencer, not the front; an idle sequencer still pops work
module dns_name_label_encoder #(
	parameter int MAX_LABEL = dnsle_pkg::MAX_LABEL_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  name_valid,
	output logic                  name_stall,
	input  dnsle_pkg::name_item_t name,
	output logic                  code_valid,
	input  logic                  code_stall,
	output dnsle_pkg::code_item_t code
);

	// front to queue
	logic            push;
	dnsle_pkg::cmd_t push_cmd;
	logic            q_full;

	// queue to back
	logic            pop;
	dnsle_pkg::cmd_t head;
	logic            q_empty;

	// label buffer write and bank hand-back
	dnsle_pkg::lbuf_wr_t  wr;
	dnsle_pkg::bank_rel_t rel;

	dnsle_front #(
		.MAX_LABEL(MAX_LABEL)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.name_valid(name_valid),
		.name_stall(name_stall),
		.name      (name),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_full    (q_full),
		.wr        (wr),
		.rel       (rel)
	);

	dnsle_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty)
	);

	dnsle_back #(
		.MAX_LABEL(MAX_LABEL)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.rel       (rel),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code      (code)
	);

endmodule

/* rtl/core/dnsle_chk.sv */
// port-level checker for the dns name label encoder, bound to the top level
// depends on dnsle_pkg and dns_name_label_encoder_macros.svh
`include "dns_name_label_encoder_macros.svh"

module dnsle_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  name_valid,
	input logic                  name_stall,
	input dnsle_pkg::name_item_t name,
	input logic                  code_valid,
	input logic                  code_stall,
	input dnsle_pkg::code_item_t code
);

	// no output item while reset holds
	`DNSLE_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !code_valid, "code_valid during reset")

	// a plain character only goes to the buffer, so it never waits
	`DNSLE_ASSERT_CLK(a_char_no_stall, clk, arst_n, (name_valid && (name.func == dnsle_pkg::FUNC_CHAR) && (name.ch != dnsle_pkg::DOT_CHAR)) |-> !name_stall, "plain character stalled")

	`DNSLE_ASSERT_CLK(a_code_hold, clk, arst_n, (code_valid && code_stall) |=> code_valid, "code_valid dropped under stall")

	`DNSLE_ASSERT_CLK(a_code_stable, clk, arst_n, (code_valid && code_stall) |=> $stable(code), "code changed under stall")

endmodule

bind dns_name_label_encoder dnsle_chk u_chk (.*);

/* tb/dns_name_label_encoder_checker.sv */
// checker for the dns name label encoder: watches both channels and scores the code bytes
// keeps its own label buffer state and a queue of expected code items
// depends on dnsle_pkg
module dns_name_label_encoder_checker #(
	parameter int MAX_LABEL = dnsle_pkg::MAX_LABEL_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  name_valid,
	input  logic                  name_stall,
	input  dnsle_pkg::name_item_t name,
	input  logic                  code_valid,
	input  logic                  code_stall,
	input  dnsle_pkg::code_item_t code,
	output int                    fail_count,
	output int                    expected_left,
	output int                    bytes_checked,
	output int                    overflow_bytes
);
	timeunit 1ns;
	timeprecision 1ps;

	import dnsle_pkg::*;

	logic [7:0]       label_bytes [MAX_LABEL];
	logic [LEN_W-1:0] label_len;
	logic             label_truncated;
	code_item_t       wire_bytes_q [$];
	code_item_t       want;
	logic             bad;

	// work out the code items caused by one accepted name item
	function automatic void predict_wire_bytes(input name_item_t it);
		code_item_t run_q [$];
		code_item_t b;
		if (it.func == FUNC_CHAR && it.ch != DOT_CHAR) begin
			if (label_len < MAX_LABEL) begin
				label_bytes[label_len] = it.ch;
				label_len = label_len + 1'b1;
			end else begin
				label_truncated = 1'b1;
			end
		end else begin
			// dot or end item closes the open label, an empty one gives nothing
			if (label_len != 0) begin
				b = '{out_byte: 8'(label_len), last: 1'b0, label_overflow: label_truncated};
				run_q.insert(run_q.size(), b);
				for (int i = 0; i < int'(label_len); i++) begin
					b = '{out_byte: label_bytes[i], last: 1'b0,
						label_overflow: label_truncated};
					run_q.insert(run_q.size(), b);
				end
			end
			label_len = '0;
			label_truncated = 1'b0;
			if (it.func == FUNC_END) begin
				if (it.pointer_offset != NO_POINTER) begin
					b = '{out_byte: POINTER_MARK | it.pointer_offset[15:8],
						last: 1'b0, label_overflow: 1'b0};
					run_q.insert(run_q.size(), b);
					b = '{out_byte: it.pointer_offset[7:0], last: 1'b0,
						label_overflow: 1'b0};
					run_q.insert(run_q.size(), b);
				end else begin
					b = '{out_byte: 8'h00, last: 1'b0, label_overflow: 1'b0};
					run_q.insert(run_q.size(), b);
				end
			end
		end
		if (run_q.size() > 0)
			run_q[run_q.size() - 1].last = 1'b1;
		foreach (run_q[i])
			wire_bytes_q.insert(wire_bytes_q.size(), run_q[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_len = '0;
			label_truncated = 1'b0;
			wire_bytes_q.delete();
			fail_count = 0;
			bytes_checked = 0;
			overflow_bytes = 0;
		end else begin
			if (name_valid && !name_stall)
				predict_wire_bytes(name);
			if (code_valid && !code_stall) begin
				if (wire_bytes_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected code item: expected none, got %02h last %b ovf %b",
						$time, code.out_byte, code.last, code.label_overflow);
				end else begin
					want = wire_bytes_q.pop_front();
					bad = 1'b0;
					if (code.out_byte !== want.out_byte) begin
						bad = 1'b1;
						$display("%0t: out_byte mismatch: expected %02h, got %02h",
							$time, want.out_byte, code.out_byte);
					end
					if (code.last !== want.last) begin
						bad = 1'b1;
						$display("%0t: last mismatch: expected %b, got %b",
							$time, want.last, code.last);
					end
					if (code.label_overflow !== want.label_overflow) begin
						bad = 1'b1;
						$display("%0t: label_overflow mismatch: expected %b, got %b",
							$time, want.label_overflow, code.label_overflow);
					end
					if (bad)
						fail_count++;
					bytes_checked++;
					if (want.label_overflow)
						overflow_bytes++;
				end
			end
		end
		expected_left = wire_bytes_q.size();
	end

endmodule

/* tb/tb_dns_name_label_encoder.sv */
// testbench top for the dns name label encoder: clock, reset, name stimulus and verdict
// depends on dnsle_pkg, dns_name_label_encoder and dns_name_label_encoder_checker
module tb_dns_name_label_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	import dnsle_pkg::*;

	localparam int MAX_LABEL    = MAX_LABEL_DEF;
	localparam int ITEM_TARGET  = 180;
	// far beyond the slowest legal run: every label byte waiting out the longest stall
	localparam int CYCLE_LIMIT  = 200000;
	// longest label replay plus a terminator, with room for stalls
	localparam int DRAIN_CYCLES = 200;

	logic       clk        = 1'b0;
	logic       arst_n;
	logic       name_valid = 1'b0;
	logic       name_stall;
	name_item_t name       = '0;
	logic       code_valid;
	logic       code_stall = 1'b0;
	code_item_t code;

	int fail_count;
	int expected_left;
	int bytes_checked;
	int overflow_bytes;

	int cycle_count = 0;
	int items_sent  = 0;
	int names_sent  = 0;
	int burst_left  = 0;

	// receiver stall pattern state
	int stall_mode      = 0;
	int stall_mode_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	dns_name_label_encoder #(
		.MAX_LABEL(MAX_LABEL)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.name_valid(name_valid),
		.name_stall(name_stall),
		.name      (name),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code      (code)
	);

	dns_name_label_encoder_checker #(
		.MAX_LABEL(MAX_LABEL)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.name_valid    (name_valid),
		.name_stall    (name_stall),
		.name          (name),
		.code_valid    (code_valid),
		.code_stall    (code_stall),
		.code          (code),
		.fail_count    (fail_count),
		.expected_left (expected_left),
		.bytes_checked (bytes_checked),
		.overflow_bytes(overflow_bytes)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// receiver: stall mode is drawn anew at random whenever its run ends
	// none, coin flip, stall when the cycle count divides by three, or long stalls
	always @(posedge clk) begin
		if (stall_mode_left == 0) begin
			stall_mode      <= $urandom_range(0, 3);
			stall_mode_left <= $urandom_range(30, 150);
		end else begin
			stall_mode_left <= stall_mode_left - 1;
		end
		case (stall_mode)
			0: begin
				code_stall <= 1'b0;
			end
			1: begin
				code_stall <= 1'($urandom_range(0, 1));
			end
			2: begin
				code_stall <= (cycle_count % 3 == 0);
			end
			default: begin
				code_stall <= (cycle_count % 16 < 7);
			end
		endcase
	end

	// watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d code items still expected",
			cycle_count, expected_left);
		$display("dns_name_label_encoder test failed");
		$finish;
	end

	// any byte but a dot
	function automatic logic [7:0] label_char();
		int v;
		v = $urandom_range(0, 254);
		if (v >= DOT_CHAR)
			v++;
		return 8'(v);
	endfunction

	// pointer offset is ignored on a character item, so it is left random
	function automatic name_item_t char_item(input logic [7:0] c);
		return '{func: FUNC_CHAR, ch: c, pointer_offset: 16'($urandom_range(0, 16'hFFFF))};
	endfunction

	// character is ignored on an end item, so it is left random
	function automatic name_item_t end_item(input logic [15:0] offset);
		return '{func: FUNC_END, ch: 8'($urandom_range(0, 255)), pointer_offset: offset};
	endfunction

	// offer one item and hold it until accepted; bursts with random gaps between them
	task automatic send_item(input name_item_t it);
		if (burst_left == 0) begin
			name_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			// now and then a long burst with no gaps at all
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
		end
		name       <= it;
		name_valid <= 1'b1;
		@(posedge clk);
		while (name_stall)
			@(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// a whole name; first_len forces the length of the first label when nonzero
	task automatic send_random_name(input int first_len);
		int n_labels;
		int len;
		logic [15:0] offset;
		if (first_len == 0 && $urandom_range(0, 7) == 0) begin
			// noise: raw bytes with dots anywhere, leading and repeated ones too
			repeat ($urandom_range(1, 12)) begin
				if ($urandom_range(0, 3) == 0)
					send_item(char_item(DOT_CHAR));
				else
					send_item(char_item(8'($urandom_range(0, 255))));
			end
		end else begin
			n_labels = (first_len != 0) ? $urandom_range(1, 3) : $urandom_range(0, 4);
			if ($urandom_range(0, 9) == 0)
				send_item(char_item(DOT_CHAR));
			for (int l = 0; l < n_labels; l++) begin
				if (l == 0 && first_len != 0)
					len = first_len;
				else if ($urandom_range(0, 19) == 0)
					len = $urandom_range(MAX_LABEL - 5, MAX_LABEL + 5);
				else
					len = $urandom_range(1, 8);
				if (l > 0) begin
					send_item(char_item(DOT_CHAR));
					if ($urandom_range(0, 9) == 0)
						send_item(char_item(DOT_CHAR));
				end
				repeat (len)
					send_item(char_item(label_char()));
			end
			// trailing dot still ends in a terminator
			if (n_labels > 0 && $urandom_range(0, 5) == 0)
				send_item(char_item(DOT_CHAR));
		end
		offset = ($urandom_range(0, 2) == 0) ? NO_POINTER : 16'($urandom_range(0, 16'hFFFF));
		send_item(end_item(offset));
		names_sent++;
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty names: zero terminator, then the lowest pointer
		send_item(end_item(NO_POINTER));
		send_item(end_item(16'h0000));
		// lone dot is an empty label, terminator still follows
		send_item(char_item(DOT_CHAR));
		send_item(end_item(16'h3FFF));
		// extreme bytes, repeated dots, trailing dot, offset above 0x4000
		send_item(char_item(8'h00));
		send_item(char_item(8'hFF));
		send_item(char_item(DOT_CHAR));
		send_item(char_item(DOT_CHAR));
		send_item(char_item(8'h61));
		send_item(char_item(DOT_CHAR));
		send_item(end_item(16'hFFFE));
		// leading dot, open label flushed by the end item
		send_item(char_item(DOT_CHAR));
		send_item(char_item(8'h41));
		send_item(char_item(8'h2D));
		send_item(end_item(16'h4001));
		// dot as the ignored character of an end item
		send_item(char_item(8'h7F));
		send_item(char_item(8'h80));
		send_item(char_item(DOT_CHAR));
		send_item('{func: FUNC_END, ch: DOT_CHAR, pointer_offset: 16'hC0A5});
		names_sent += 6;

		// one label at the maximum, one that loses characters, then random names
		send_random_name(MAX_LABEL);
		send_random_name(MAX_LABEL + 3);
		while (items_sent < ITEM_TARGET)
			send_random_name(0);
		name_valid <= 1'b0;

		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d names in %0d items; checked %0d code bytes, %0d on overflowed labels",
			names_sent, items_sent, bytes_checked, overflow_bytes);
		if (fail_count == 0 && expected_left == 0) begin
			$display("dns_name_label_encoder test passed");
		end else begin
			$display("%0d failures, %0d code items never arrived", fail_count, expected_left);
			$display("dns_name_label_encoder test failed");
		end
		$finish;
	end

endmodule
